>>> rtl/ntpta_pkg.sv
// Package for the nearest-target pan/tilt aim block.
// Holds the sequencer state type, register indexes, formats and the arctangent table.
// No dependencies.
package ntpta_pkg;

  localparam int ANG_FRAC = 20;
  localparam int PI_Q20   = 3294199;
  localparam int PI_Q12   = 12868;
  localparam int TAB_LEN  = 24;

  localparam logic [13:0] TILT_ZERO_RANGE = 14'sd819;
  localparam logic [16:0] GAIN_ONE        = 17'd65536;
  localparam logic [8:0]  TIME_SLOW_MS    = 9'd500;
  localparam logic [8:0]  TIME_FAST_MS    = 9'd50;

  localparam logic [2:0] REG_SMOOTH   = 3'd0;
  localparam logic [2:0] REG_GAIN     = 3'd1;
  localparam logic [2:0] REG_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_TILT_LO  = 3'd3;
  localparam logic [2:0] REG_TILT_HI  = 3'd4;
  localparam logic [2:0] REG_ROTATE   = 3'd5;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_BLEND  = 10'b0000000010,
    ST_SQ     = 10'b0000000100,
    ST_SQRT   = 10'b0000001000,
    ST_PAN_I  = 10'b0000010000,
    ST_CORDIC = 10'b0000100000,
    ST_PAN_F  = 10'b0001000000,
    ST_TILT_I = 10'b0010000000,
    ST_TILT_F = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  function automatic logic [22:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 23'd823550;
      5'd1:  atan_lut = 23'd486170;
      5'd2:  atan_lut = 23'd256879;
      5'd3:  atan_lut = 23'd130396;
      5'd4:  atan_lut = 23'd65451;
      5'd5:  atan_lut = 23'd32757;
      5'd6:  atan_lut = 23'd16383;
      5'd7:  atan_lut = 23'd8192;
      5'd8:  atan_lut = 23'd4096;
      5'd9:  atan_lut = 23'd2048;
      5'd10: atan_lut = 23'd1024;
      5'd11: atan_lut = 23'd512;
      5'd12: atan_lut = 23'd256;
      5'd13: atan_lut = 23'd128;
      5'd14: atan_lut = 23'd64;
      5'd15: atan_lut = 23'd32;
      5'd16: atan_lut = 23'd16;
      5'd17: atan_lut = 23'd8;
      5'd18: atan_lut = 23'd4;
      5'd19: atan_lut = 23'd2;
      5'd20: atan_lut = 23'd1;
      default: atan_lut = 23'd0;
    endcase
  endfunction

endpackage

>>> rtl/nearest_target_pan_tilt_aim.sv
// Nearest-target pan/tilt aim: per-frame nearest detection, tracking, pan/tilt via CORDIC.
// Depends on ntpta_pkg.
//
// Non-final items: accepted back to back while in_tready is high (compare on a combinational square sum).
// Frame end: blend (a direct copy with smoothing off), square sum, bit-serial square root,
// then two CORDIC vectoring runs (pan, then tilt) on one shared add/shift unit, each with a
// load and a finish state; out_tvalid then rises only when rotate is set (else the result is
// not presented); in_tready is low meanwhile.
// Result waits in the output register; next frame starts the cycle after it is taken.
// Reset (rst_n low, synchronous) loads register defaults, clears best and track state.
module nearest_target_pan_tilt_aim #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: det_x, det_y (lowest first), zero padded to bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // tuser: present
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: pan[14:0], tilt[28:15], move_time_ms[37:29], zero padded
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import ntpta_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int SQW = 2*CW + 1;              // x*x + y*y
  localparam int RW  = CW + 1;                // sqrt width
  localparam int CXW = CW + ANG_FRAC + 3;     // CORDIC datapath
  localparam int ZW  = 25;
  localparam int SCW = $clog2(CORDIC_STEPS + 1);
  localparam int QCW = $clog2(RW + 1);

  // config registers
  logic               smooth_r, rotate_r;
  logic [16:0]        gain_r;
  logic [11:0]        height_r;
  logic signed [13:0] tlo_r, thi_r;

  logic [SQW-1:0]       best_sq_r;
  logic                 best_none_r;
  logic signed [CW-1:0] best_x_r, best_y_r, trk_x_r, trk_y_r;
  state_t               st_r;

  logic signed [CW-1:0] dx, dy;
  logic                 present;
  assign dx      = in_tdata[CW-1:0];
  assign dy      = in_tdata[2*CW-1:CW];
  assign present = in_tuser;

  // signed multiplier for the blend
  logic signed [CW+17:0] mul_a, mul_p;
  logic signed [17:0]    mul_b;
  assign mul_p = mul_a * mul_b;

  logic [SQW-1:0] det_sq;
  assign det_sq = SQW'(dx) * SQW'(dx) + SQW'(dy) * SQW'(dy);

  logic in_fire, out_fire;
  assign in_tready = (st_r == ST_IDLE) && !out_tvalid;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  logic [16:0] g_sat;
  assign g_sat = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;

  // blend: g*old + (1-g)*best = g*(old-best) + best*65536
  logic signed [CW:0]    diff;
  logic signed [CW+18:0] bl_sum;
  logic                  bl_y_r;
  logic signed [CW+17:0] blx_r;
  assign diff  = bl_y_r ? (CW+1)'(trk_y_r) - (CW+1)'(best_y_r)
                        : (CW+1)'(trk_x_r) - (CW+1)'(best_x_r);
  assign mul_a = (CW+18)'(diff);
  assign mul_b = 18'($signed({1'b0, g_sat}));
  assign bl_sum = (CW+19)'(mul_p)
                + (CW+19)'($signed({bl_y_r ? best_y_r : best_x_r, 16'd0}))
                + (CW+19)'(32768);

  // square root (restoring, one result bit a cycle, operand padded to even width)
  logic [RW-1:0]   rem_r;
  logic [2*RW-1:0] sqv_r;
  logic [RW-1:0]   root_r;
  logic [QCW-1:0]  qcnt_r;
  logic [RW+1:0]   trial;
  logic [RW+1:0]   rem_sh;
  assign rem_sh = {rem_r, sqv_r[2*RW-1 -: 2]};
  assign trial  = rem_sh - {root_r, 2'b01};

  // CORDIC shared unit
  logic signed [CXW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0]  cz_r;
  logic [SCW-1:0]        ci_r;
  logic signed [CXW-1:0] sx, sy;
  logic [4:0]            ci5;
  assign ci5 = 5'(ci_r);
  assign sx  = cx_r >>> ci_r;
  assign sy  = cy_r >>> ci_r;

  logic signed [ZW-1:0] zr;
  logic signed [14:0]   ang_q;
  assign zr    = (cz_r + ZW'(128)) >>> (ANG_FRAC - 12);
  assign ang_q = (zr > ZW'(PI_Q12)) ? 15'(PI_Q12)
               : (zr < -ZW'(PI_Q12)) ? -15'(PI_Q12) : 15'(zr);

  logic signed [14:0] pan_r;
  logic               zero_r;

  // load CORDIC from (y, x) with left-half-plane fold
  function automatic logic [2*CXW+ZW-1:0] cload(input logic signed [CXW-1:0] y,
                                                 input logic signed [CXW-1:0] x);
    logic signed [ZW-1:0] z;
    z = '0;
    if (x < 0) begin
      z = (y >= 0) ? ZW'(PI_Q20) : -ZW'(PI_Q20);
      x = -x;
      y = -y;
    end
    cload = {x, y, z};
  endfunction

  logic signed [13:0] tilt_q;
  assign tilt_q = (14'(ang_q) < tlo_r) ? tlo_r : (14'(ang_q) > thi_r) ? thi_r : 14'(ang_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= 1'b1; gain_r <= 17'd32768; height_r <= 12'd1741;
      tlo_r <= -14'sd1072; thi_r <= 14'sd1072; rotate_r <= 1'b1;
      best_none_r <= 1'b1; best_x_r <= '0; best_y_r <= '0; best_sq_r <= '1;
      trk_x_r <= '0; trk_y_r <= '0;
      st_r <= ST_IDLE; out_tvalid <= 1'b0; bl_y_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SMOOTH:  smooth_r <= cfg_data[0];
          REG_GAIN:    gain_r   <= cfg_data;
          REG_HEIGHT:  height_r <= cfg_data[11:0];
          REG_TILT_LO: tlo_r    <= cfg_data[13:0];
          REG_TILT_HI: thi_r    <= cfg_data[13:0];
          REG_ROTATE:  rotate_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_fire) out_tvalid <= 1'b0;
      case (st_r)
        ST_IDLE: if (in_fire) begin
          if (present && (best_none_r || det_sq < best_sq_r)) begin
            best_sq_r <= det_sq; best_x_r <= dx; best_y_r <= dy; best_none_r <= 1'b0;
          end
          if (in_tlast) begin
            st_r <= ST_BLEND;
            bl_y_r <= 1'b0;
          end
        end
        ST_BLEND: begin
          // best registers already hold the final comparison
          if (!smooth_r) begin
            trk_x_r <= best_x_r; trk_y_r <= best_y_r; st_r <= ST_SQ;
          end else if (!bl_y_r) begin
            blx_r <= (CW+18)'(bl_sum >>> 16); bl_y_r <= 1'b1;
          end else begin
            trk_x_r <= CW'(blx_r); trk_y_r <= CW'(bl_sum >>> 16); st_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          best_none_r <= 1'b1; best_sq_r <= '1; best_x_r <= '0; best_y_r <= '0;
          sqv_r <= (2*RW)'(SQW'(trk_x_r) * SQW'(trk_x_r) + SQW'(trk_y_r) * SQW'(trk_y_r));
          rem_r <= '0; root_r <= '0; qcnt_r <= '0;
          st_r <= ST_SQRT;
        end
        ST_SQRT: begin
          sqv_r <= {sqv_r[2*RW-3:0], 2'b00};
          if (!trial[RW+1]) begin
            rem_r  <= trial[RW-1:0];
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[RW-1:0];
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          qcnt_r <= qcnt_r + 1'b1;
          if (qcnt_r == QCW'(RW-1)) st_r <= ST_PAN_I;
        end
        ST_PAN_I: begin
          zero_r <= (root_r == '0);
          {cx_r, cy_r, cz_r} <= cload(CXW'(trk_y_r) <<< ANG_FRAC, CXW'(trk_x_r) <<< ANG_FRAC);
          ci_r <= '0;
          st_r <= ST_CORDIC;
          bl_y_r <= 1'b0; // pan pass
        end
        ST_CORDIC: begin
          if (ci_r == SCW'(CORDIC_STEPS)) begin
            st_r <= bl_y_r ? ST_TILT_F : ST_PAN_F;
          end else begin
            if (cy_r > 0) begin
              cx_r <= cx_r + sy; cy_r <= cy_r - sx; cz_r <= cz_r + ZW'(atan_lut(ci5));
            end else begin
              cx_r <= cx_r - sy; cy_r <= cy_r + sx; cz_r <= cz_r - ZW'(atan_lut(ci5));
            end
            ci_r <= ci_r + 1'b1;
          end
        end
        ST_PAN_F: begin
          pan_r <= zero_r ? 15'sd0 : ang_q;
          st_r <= ST_TILT_I;
        end
        ST_TILT_I: begin
          {cx_r, cy_r, cz_r} <= cload(CXW'({1'b0, height_r}) <<< ANG_FRAC,
                                      CXW'({1'b0, root_r}) <<< ANG_FRAC);
          ci_r <= '0; bl_y_r <= 1'b1;
          st_r <= ST_CORDIC;
        end
        ST_TILT_F: begin
          out_tdata <= {2'b00,
                        zero_r ? TIME_SLOW_MS : TIME_FAST_MS,
                        zero_r ? TILT_ZERO_RANGE : tilt_q,
                        pan_r};
          st_r <= ST_OUT;
        end
        ST_OUT: begin
          out_tvalid <= rotate_r;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_TILT_F) |=> (st_r == ST_OUT))
    else $error("sequencer skipped output");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule
